[rtl/sbfd_pkg.sv]
// shared types, constants and channel scaling for the s.bus frame decoder
`default_nettype none

package sbfd_pkg;

    localparam int FRAME_BYTES = 25;
    localparam int NUM_ANALOG  = 16;
    localparam int NUM_RESULTS = 18;
    localparam int CH_BITS     = 11;
    localparam int CHAN_VEC_W  = NUM_ANALOG * CH_BITS;

    localparam logic [7:0] START_MARKER_RST = 8'd15;
    localparam logic [7:0] END_MARKER_RST   = 8'd0;

    localparam logic [11:0] VAL_LOW  = 12'd1000;
    localparam logic [11:0] VAL_HIGH = 12'd2000;
    localparam logic [11:0] VAL_BASE = 12'd880;

    localparam int FLAG_DIG0 = 0;
    localparam int FLAG_DIG1 = 1;
    localparam int FLAG_LOST = 2;
    localparam int FLAG_FS   = 3;

    typedef enum logic {
        CFG_START_MARKER = 1'b0,
        CFG_END_MARKER   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                  load;
        logic [CHAN_VEC_W-1:0] chans;
        logic [7:0]            flags;
    } t_frame_cap;

    // 5*x/8 + 880
    function automatic logic [11:0] scale_channel(input logic [CH_BITS-1:0] raw);
        logic [13:0] prod;
        prod = 14'(raw) * 14'd5;
        return 12'(prod >> 3) + VAL_BASE;
    endfunction

endpackage

`default_nettype wire

[rtl/sbfd_emitter.sv]
// frame holding register, channel sequencer and registered result word
`default_nettype none

module sbfd_emitter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sbfd_pkg::t_frame_cap i_cap,
    output logic                    o_busy,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [4:0]              o_channel_index,
    output logic [11:0]             o_channel_value,
    output logic                    o_lost_frame,
    output logic                    o_fail_safe,
    output logic                    o_last_of_frame
);
    import sbfd_pkg::*;

    localparam logic [4:0] LAST_CHAN = 5'(NUM_RESULTS - 1);
    localparam logic [4:0] DIG0_CHAN = 5'(NUM_ANALOG);

    logic                  r_busy;
    logic [4:0]            r_chan;
    logic [CHAN_VEC_W-1:0] r_chans;
    logic [7:0]            r_flags;

    logic                  r_valid;
    logic [4:0]            r_idx;
    logic [11:0]           r_val;
    logic                  r_lost;
    logic                  r_fs;
    logic                  r_last;

    logic                  load_out;
    logic [7:0]            bit_base;
    logic [CH_BITS-1:0]    raw;
    logic [11:0]           n_val;
    logic                  n_valid;

    assign load_out = r_busy && (!r_valid || !i_stall);
    assign bit_base = 8'(r_chan[3:0]) * 8'(CH_BITS);
    assign raw      = r_chans[bit_base +: CH_BITS];

    always_comb begin
        priority if (r_chan < DIG0_CHAN) begin
            n_val = scale_channel(raw);
        end else if (r_chan == DIG0_CHAN) begin
            n_val = r_flags[FLAG_DIG0] ? VAL_HIGH : VAL_LOW;
        end else begin
            n_val = r_flags[FLAG_DIG1] ? VAL_HIGH : VAL_LOW;
        end
    end

    always_comb begin
        if (load_out) begin
            n_valid = 1'b1;
        end else begin
            n_valid = r_valid && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_chan  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cap.load) begin
                r_busy <= 1'b1;
                r_chan <= '0;
            end else if (load_out) begin
                r_chan <= r_chan + 5'd1;
                if (r_chan == LAST_CHAN) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cap.load) begin
            r_chans <= i_cap.chans;
            r_flags <= i_cap.flags;
        end
        if (load_out) begin
            r_idx  <= r_chan;
            r_val  <= n_val;
            r_lost <= r_flags[FLAG_LOST];
            r_fs   <= r_flags[FLAG_FS];
            r_last <= (r_chan == LAST_CHAN);
        end
    end

    assign o_busy          = r_busy;
    assign o_valid         = r_valid;
    assign o_channel_index = r_idx;
    assign o_channel_value = r_val;
    assign o_lost_frame    = r_lost;
    assign o_fail_safe     = r_fs;
    assign o_last_of_frame = r_last;

endmodule

`default_nettype wire

[rtl/sbus_frame_decoder_top.sv]
// s.bus frame decoder: byte window, marker match and frame capture
//
// input channel: one received byte per word (i_rx_byte), taken when i_in_valid
// is high and o_in_stall is low. bytes slide through a 25 byte window; when
// the window is full, its oldest byte equals the start marker and the new byte
// equals the end marker, the frame is captured and the window is emptied.
// output channel: 18 words per frame, channels 0-15 analog (5*x/8+880) then
// the two digital channels (1000 or 2000), each word carrying the lost-frame
// and failsafe flags; o_last_of_frame marks channel 17. a word is taken when
// o_out_valid is high and i_out_stall is low.
// throughput: one byte per cycle while o_in_stall is low. the closing byte
// loads the frame holding register, the sequencer then moves the first word
// to the output register, then one word per cycle while i_out_stall is low.
// o_in_stall rises only while a frame is still draining and the next byte
// could close another frame; a stalled receiver holds the output word.
// config: plain write port; the user writes markers while the block is idle;
// the block does not enforce this. reset (synchronous, active low) empties
// the window, drops any pending results and sets the markers to 15 and 0.
`default_nettype none

module sbus_frame_decoder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_channel_index,
    output logic [11:0]      o_channel_value,
    output logic             o_lost_frame,
    output logic             o_fail_safe,
    output logic             o_last_of_frame
);
    import sbfd_pkg::*;

    localparam logic [4:0] FILL_FULL = 5'(FRAME_BYTES);
    localparam logic [4:0] FILL_NEAR = 5'(FRAME_BYTES - 1);

    logic [7:0] r_start;
    logic [7:0] r_end;
    logic [7:0] r_win [FRAME_BYTES];
    logic [4:0] r_fill;
    logic [4:0] n_fill;

    logic       accept;
    logic       hit;
    logic       busy;
    t_frame_cap cap;

    assign o_in_stall = busy && (r_fill >= FILL_NEAR);
    assign accept     = i_in_valid && !o_in_stall;
    assign hit        = accept && (r_fill >= FILL_NEAR)
                        && (r_win[1] == r_start) && (i_rx_byte == r_end);

    always_comb begin
        cap.load  = hit;
        cap.flags = r_win[FRAME_BYTES - 1];
        for (int k = 0; k < 2 * NUM_ANALOG * CH_BITS / 16; k++) begin
            cap.chans[k*8 +: 8] = r_win[k + 2];
        end
    end

    always_comb begin
        if (hit) begin
            n_fill = '0;
        end else if (r_fill == FILL_FULL) begin
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_MARKER_RST;
            r_end   <= END_MARKER_RST;
            r_fill  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_START_MARKER: r_start <= i_cfg_data;
                    CFG_END_MARKER:   r_end   <= i_cfg_data;
                endcase
            end
            if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[FRAME_BYTES - 1] <= i_rx_byte;
        end
    end

    sbfd_emitter u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cap           (cap),
        .o_busy          (busy),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_lost_frame    (o_lost_frame),
        .o_fail_safe     (o_fail_safe),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire

[dv/tb_top.sv]
// testbench for sbus_frame_decoder_top: directed frame table, then random frames and noise
`timescale 1ns / 1ps

module tb_top;
    import sbfd_pkg::*;

    localparam int CLK_HALF_NS     = 10;
    localparam int WATCHDOG_CYCLES = 200000;
    localparam int DRAIN_LIMIT     = 5000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int IDLE_PCT        = 24;

    typedef struct packed {
        logic [4:0]  idx;
        logic [11:0] value;
        logic        lost;
        logic        fs;
        logic        last;
    } t_chan_word;

    typedef struct {
        logic [7:0]  rx;
        bit          typed;
        logic [11:0] analog_val;
        logic [11:0] digital_val;
        logic        lost;
        logic        fs;
    } t_stim_row;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    t_cfg_reg   cfg_idx   = CFG_START_MARKER;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_stall = 1'b0;

    wire        in_stall;
    wire        out_valid;
    wire [4:0]  out_index;
    wire [11:0] out_value;
    wire        out_lost;
    wire        out_fs;
    wire        out_last;

    sbus_frame_decoder_top DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_channel_index (out_index),
        .o_channel_value (out_value),
        .o_lost_frame    (out_lost),
        .o_fail_safe     (out_fs),
        .o_last_of_frame (out_last)
    );

    always begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    logic [7:0]  window [FRAME_BYTES];
    int unsigned window_fill;
    logic [7:0]  start_mk = START_MARKER_RST;
    logic [7:0]  end_mk   = END_MARKER_RST;
    t_chan_word  pending_channels[$];
    t_stim_row   tbl[$];
    int unsigned fault_count = 0;
    int unsigned idle_pct    = IDLE_PCT;

    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endfunction

    function automatic string fmt_word(input t_chan_word w);
        return $sformatf("ch %0d value %0d lost %b fs %b last %b",
                         w.idx, w.value, w.lost, w.fs, w.last);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < FRAME_BYTES; i++) begin
            window[i] = 8'h00;
        end
        window_fill = 0;
    endfunction

    function automatic void decode_frame();
        logic [7:0]         flags;
        logic [CH_BITS-1:0] raw;
        int unsigned        bitpos;
        t_chan_word         w;
        flags = window[23];
        for (int ch = 0; ch < NUM_RESULTS; ch++) begin
            if (ch < NUM_ANALOG) begin
                for (int b = 0; b < CH_BITS; b++) begin
                    bitpos = ch * CH_BITS + b;
                    raw[b] = window[1 + bitpos / 8][bitpos % 8];
                end
                w.value = 12'(int'(raw) * 5 / 8) + VAL_BASE;
            end else if (ch == NUM_ANALOG) begin
                w.value = flags[FLAG_DIG0] ? VAL_HIGH : VAL_LOW;
            end else begin
                w.value = flags[FLAG_DIG1] ? VAL_HIGH : VAL_LOW;
            end
            w.idx  = 5'(ch);
            w.lost = flags[FLAG_LOST];
            w.fs   = flags[FLAG_FS];
            w.last = (ch == NUM_RESULTS - 1);
            pending_channels.push_back(w);
        end
    endfunction

    // slide the byte in; a matched frame is decoded when predict is set, and the window emptied
    function automatic void shift_in_byte(input logic [7:0] b, input bit predict);
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            window[i] = window[i + 1];
        end
        window[FRAME_BYTES - 1] = b;
        if (window_fill < FRAME_BYTES) begin
            window_fill++;
        end
        if (window_fill == FRAME_BYTES && window[0] == start_mk
                && window[FRAME_BYTES - 1] == end_mk) begin
            if (predict) begin
                decode_frame();
            end
            clear_window();
        end
    endfunction

    function automatic void push_typed(input t_stim_row r);
        t_chan_word w;
        for (int ch = 0; ch < NUM_RESULTS; ch++) begin
            w.idx   = 5'(ch);
            w.value = (ch < NUM_ANALOG) ? r.analog_val : r.digital_val;
            w.lost  = r.lost;
            w.fs    = r.fs;
            w.last  = (ch == NUM_RESULTS - 1);
            pending_channels.push_back(w);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit predict);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        shift_in_byte(b, predict);
    endtask

    task automatic set_markers(input logic [7:0] s, input logic [7:0] e);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_START_MARKER;
        cfg_data <= s;
        @(posedge clk);
        cfg_idx  <= CFG_END_MARKER;
        cfg_data <= e;
        @(posedge clk);
        cfg_we   <= 1'b0;
        start_mk = s;
        end_mk   = e;
    endtask

    task automatic drain_and_settle();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (pending_channels.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input logic [7:0] s, input logic [7:0] e);
        int unsigned mode;
        mode = $urandom_range(3);
        send_byte(s, 1'b1);
        repeat (22) begin
            case (mode)
                0:       send_byte(8'h00, 1'b1);
                1:       send_byte(8'hFF, 1'b1);
                default: send_byte(8'($urandom_range(255)), 1'b1);
            endcase
        end
        send_byte(8'($urandom_range(255)), 1'b1);
        send_byte(e, 1'b1);
    endtask

    // noise, broken frame or whole frame
    task automatic send_chunk(input logic [7:0] s, input logic [7:0] e);
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(99);
        if (kind < 20) begin
            send_frame(s, e);
        end else if (kind < 70) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                send_byte(($urandom_range(2) == 0) ? e : 8'($urandom_range(255)), 1'b1);
            end
        end else begin
            send_byte(s, 1'b1);
            n = $urandom_range(1, 8);
            repeat (n) send_byte(8'($urandom_range(255)), 1'b1);
        end
    endtask

    task automatic run_phase(input logic [7:0] s, input logic [7:0] e, input bit quiet);
        set_markers(s, e);
        idle_pct = quiet ? 0 : IDLE_PCT;
        send_chunk(s, e);
        send_frame(s, e);
        drain_and_settle();
        idle_pct = IDLE_PCT;
    endtask

    always @(posedge clk) begin : word_sink
        t_chan_word got;
        t_chan_word want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            got = {out_index, out_value, out_lost, out_fs, out_last};
            if (pending_channels.size() == 0) begin
                log_fault({"unexpected word: ", fmt_word(got)});
            end else begin
                want = pending_channels.pop_front();
                if (got !== want) begin
                    log_fault({"mismatch: expected ", fmt_word(want),
                               ", got ", fmt_word(got)});
                end
            end
        end
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    initial begin : stimulus
        logic [7:0] v;
        clear_window();

        // stray byte, then a frame of all ones with every flag bit set
        tbl.push_back(t_stim_row'{8'h00, 1'b0, 12'd0, 12'd0, 1'b0, 1'b0});
        tbl.push_back(t_stim_row'{START_MARKER_RST, 1'b0, 12'd0, 12'd0, 1'b0, 1'b0});
        for (int i = 0; i < 23; i++) begin
            tbl.push_back(t_stim_row'{8'hFF, 1'b0, 12'd0, 12'd0, 1'b0, 1'b0});
        end
        tbl.push_back(t_stim_row'{END_MARKER_RST, 1'b1, 12'd2159, VAL_HIGH, 1'b1, 1'b1});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (tbl[i]) begin
            send_byte(tbl[i].rx, !tbl[i].typed);
            if (tbl[i].typed) begin
                push_typed(tbl[i]);
            end
        end
        drain_and_settle();

        run_phase(8'h00, 8'hFF, 1'b0);
        run_phase(8'hFF, 8'h00, 1'b1);
        v = 8'($urandom_range(255));
        run_phase(v, v, 1'b0);

        if (pending_channels.size() != 0) begin
            log_fault($sformatf("%0d channel words never arrived", pending_channels.size()));
        end
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(2 * CLK_HALF_NS * WATCHDOG_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sbus_frame_decoder_top.f]
rtl/sbfd_pkg.sv
rtl/sbfd_emitter.sv
rtl/sbus_frame_decoder_top.sv
dv/tb_top.sv
